FILE: rtl/pxud_pkg.sv
// Shared types and constants of the pixel undistortion pipeline.
package pxud_pkg;

  typedef enum logic [2:0] {
    REG_PIXEL_GAIN    = 3'd0,
    REG_CENTER_X_NORM = 3'd1,
    REG_CENTER_Y_NORM = 3'd2,
    REG_RADIAL_K1     = 3'd3,
    REG_RADIAL_K2     = 3'd4,
    REG_PLANE_DEPTH   = 3'd5,
    REG_OFFSET_X      = 3'd6,
    REG_OFFSET_Y      = 3'd7
  } reg_idx_e;

  localparam int unsigned FRAC     = 28;
  localparam int unsigned QBITS    = 32;
  localparam int unsigned DIVR_W   = 37;
  localparam int unsigned LO_W     = QBITS - FRAC;
  localparam int unsigned DIV_LAT  = QBITS + 2;
  localparam int unsigned FRONT_ST = 9;
  localparam int unsigned NSTG     = FRONT_ST + DIV_LAT + 1;

endpackage

FILE: rtl/pxud_div.sv
// Pipelined restoring divider with a saturated signed 32-bit quotient.
module pxud_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [31:0]                        mag_i,
  input  logic                               neg_i,
  input  logic [pxud_pkg::DIVR_W-1:0]        divisor_i,
  output logic signed [31:0]                 quot_o
);

  logic [pxud_pkg::DIVR_W-1:0] dvs_q [pxud_pkg::QBITS+1];
  logic [pxud_pkg::DIVR_W-1:0] rem_q [pxud_pkg::QBITS+1];
  logic [pxud_pkg::QBITS-1:0]  quo_q [pxud_pkg::QBITS+1];
  logic [pxud_pkg::LO_W-1:0]   lo_q  [pxud_pkg::QBITS+1];
  logic                        neg_q [pxud_pkg::QBITS+1];
  logic                        ovf_q [pxud_pkg::QBITS+1];
  logic signed [31:0]          quot_q;
  logic [pxud_pkg::QBITS-1:0]  qf;

  // The dividend is the magnitude shifted up by the fraction width; its bits above
  // the quotient width form the starting remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q[0] <= divisor_i;
      rem_q[0] <= pxud_pkg::DIVR_W'(mag_i[31:pxud_pkg::LO_W]);
      ovf_q[0] <= (pxud_pkg::DIVR_W'(mag_i[31:pxud_pkg::LO_W]) >= divisor_i);
      quo_q[0] <= '0;
      lo_q[0]  <= mag_i[pxud_pkg::LO_W-1:0];
      neg_q[0] <= neg_i;
    end
  end

  for (genvar i = 0; i < pxud_pkg::QBITS; i++) begin : g_step
    localparam int unsigned J = pxud_pkg::QBITS - 1 - i;
    logic                         nb;
    logic [pxud_pkg::DIVR_W:0]    trial;
    logic [pxud_pkg::DIVR_W:0]    diff;
    logic                         take;
    logic [pxud_pkg::QBITS-1:0]   quo_d;

    if (J >= pxud_pkg::FRAC) begin : g_bit
      assign nb = lo_q[i][J-pxud_pkg::FRAC];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {rem_q[i], nb};
    assign diff  = trial - {1'b0, dvs_q[i]};
    assign take  = (trial >= {1'b0, dvs_q[i]});

    always_comb begin
      quo_d    = quo_q[i];
      quo_d[J] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= take ? diff[pxud_pkg::DIVR_W-1:0] : trial[pxud_pkg::DIVR_W-1:0];
        quo_q[i+1] <= quo_d;
        dvs_q[i+1] <= dvs_q[i];
        lo_q[i+1]  <= lo_q[i];
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
  end

  assign qf = quo_q[pxud_pkg::QBITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!neg_q[pxud_pkg::QBITS]) begin
        if (ovf_q[pxud_pkg::QBITS] || qf[31]) begin
          quot_q <= 32'sh7fffffff;
        end else begin
          quot_q <= $signed(qf);
        end
      end else begin
        if (ovf_q[pxud_pkg::QBITS] || (qf[31] && (qf[30:0] != '0))) begin
          quot_q <= $signed(32'h80000000);
        end else begin
          quot_q <= $signed(32'(~qf + 32'd1));
        end
      end
    end
  end

  assign quot_o = quot_q;

endmodule

FILE: rtl/pixel_undistort_to_world_coordinates.sv
// Top level: undistorts a camera pixel pair and maps it to world coordinates.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one pixel pair per transaction.
//   Output channel (out_valid_o/out_ready_i) returns world_x_o, world_y_o and
//   invalid_o, one transaction per input, in order.
//   Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i selecting
//   the register; cfg_ready_o is always high. Write only while the block is idle.
// Throughput and pipeline:
//   One pixel pair is accepted per cycle while in_ready_o is high. The pipeline
//   is made of the 32-step pipelined divider, which produces one quotient bit
//   per stage, plus the multiplier stages.
// Reset:
//   All configuration registers clear to zero and the pipeline empties.
// Back-pressure:
//   When the receiver stalls, one further result lands in a skid register and
//   in_ready_o drops in the next cycle; the whole pipeline then holds until the
//   skid register drains. in_ready_o is driven from a register.
module pixel_undistort_to_world_coordinates (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [9:0]         pixel_x_i,
  input  logic [9:0]         pixel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  output logic               invalid_o
);

  localparam int unsigned LAST = pxud_pkg::NSTG - 1;

  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] a);
    logic signed [31:0] r;
    if (a > 64'sh000000007fffffff) begin
      r = 32'sh7fffffff;
    end else if (a < $signed(64'hffffffff80000000)) begin
      r = $signed(32'h80000000);
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [30:0]        gain_q;
  logic signed [31:0] cen_q [2];
  logic signed [31:0] k1_q;
  logic signed [31:0] k2_q;
  logic [30:0]        depth_q;
  logic signed [31:0] off_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      k1_q     <= '0;
      k2_q     <= '0;
      depth_q  <= '0;
      off_q[0] <= '0;
      off_q[1] <= '0;
    end else if (cfg_valid_i) begin
      unique case (pxud_pkg::reg_idx_e'(cfg_index_i))
        pxud_pkg::REG_PIXEL_GAIN:    gain_q   <= cfg_data_i[30:0];
        pxud_pkg::REG_CENTER_X_NORM: cen_q[0] <= $signed(cfg_data_i);
        pxud_pkg::REG_CENTER_Y_NORM: cen_q[1] <= $signed(cfg_data_i);
        pxud_pkg::REG_RADIAL_K1:     k1_q     <= $signed(cfg_data_i);
        pxud_pkg::REG_RADIAL_K2:     k2_q     <= $signed(cfg_data_i);
        pxud_pkg::REG_PLANE_DEPTH:   depth_q  <= cfg_data_i[30:0];
        pxud_pkg::REG_OFFSET_X:      off_q[0] <= $signed(cfg_data_i);
        pxud_pkg::REG_OFFSET_Y:      off_q[1] <= $signed(cfg_data_i);
        default:                     gain_q   <= gain_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Pipeline control.
  logic                          en;
  logic [pxud_pkg::NSTG-1:0]     v_q;
  logic                          out_valid_q;
  logic                          skid_valid_q;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[pxud_pkg::NSTG-2:0], in_valid_i};
    end
  end

  // Front stages: normalize, square, radial polynomial.
  logic [9:0]                 pix [2];
  logic [40:0]                s1_prod_q [2];
  logic signed [31:0]         s2_u_q [2];
  logic [31:0]                s3_mag_q [2];
  logic                       s3_neg_q [2];
  logic [63:0]                s4_sq_q [2];
  logic [31:0]                s4_mag_q [2];
  logic                       s4_neg_q [2];
  logic [31:0]                s5_r2_q;
  logic [31:0]                s5_mag_q [2];
  logic                       s5_neg_q [2];
  logic [63:0]                s6_r2sq_q;
  logic signed [64:0]         s6_k1r2_q;
  logic [31:0]                s6_mag_q [2];
  logic                       s6_neg_q [2];
  logic [31:0]                s7_r4_q;
  logic signed [36:0]         s7_t1_q;
  logic [31:0]                s7_mag_q [2];
  logic                       s7_neg_q [2];
  logic signed [64:0]         s8_k2r4_q;
  logic signed [36:0]         s8_t1_q;
  logic [31:0]                s8_mag_q [2];
  logic                       s8_neg_q [2];
  logic signed [38:0]         s9_d_q;
  logic [31:0]                s9_mag_q [2];
  logic                       s9_neg_q [2];
  logic [64:0]                r2_sum;
  logic signed [63:0]         u_diff [2];

  assign pix[0] = pixel_x_i;
  assign pix[1] = pixel_y_i;
  assign r2_sum = {1'b0, s4_sq_q[0]} + {1'b0, s4_sq_q[1]};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      u_diff[l] = $signed({23'b0, s1_prod_q[l]}) - 64'(cen_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        s1_prod_q[l] <= 41'(pix[l]) * 41'(gain_q);
        s2_u_q[l]    <= sat_s32(u_diff[l]);
        s3_mag_q[l]  <= s2_u_q[l][31] ? 32'(~s2_u_q[l] + 32'sd1) : s2_u_q[l];
        s3_neg_q[l]  <= s2_u_q[l][31];
        s4_sq_q[l]   <= 64'(s3_mag_q[l]) * 64'(s3_mag_q[l]);
        s4_mag_q[l]  <= s3_mag_q[l];
        s4_neg_q[l]  <= s3_neg_q[l];
        s5_mag_q[l]  <= s4_mag_q[l];
        s5_neg_q[l]  <= s4_neg_q[l];
        s6_mag_q[l]  <= s5_mag_q[l];
        s6_neg_q[l]  <= s5_neg_q[l];
        s7_mag_q[l]  <= s6_mag_q[l];
        s7_neg_q[l]  <= s6_neg_q[l];
        s8_mag_q[l]  <= s7_mag_q[l];
        s8_neg_q[l]  <= s7_neg_q[l];
        s9_mag_q[l]  <= s8_mag_q[l];
        s9_neg_q[l]  <= s8_neg_q[l];
      end
      s5_r2_q   <= (r2_sum[64:60] != '0) ? '1 : r2_sum[59:28];
      s6_r2sq_q <= 64'(s5_r2_q) * 64'(s5_r2_q);
      s6_k1r2_q <= k1_q * $signed({1'b0, s5_r2_q});
      s7_r4_q   <= (s6_r2sq_q[63:60] != '0) ? '1 : s6_r2sq_q[59:28];
      s7_t1_q   <= s6_k1r2_q[64:28];
      s8_k2r4_q <= k2_q * $signed({1'b0, s7_r4_q});
      s8_t1_q   <= s7_t1_q;
      s9_d_q    <= 39'sd268435456 + 39'(s8_t1_q) + 39'($signed(s8_k2r4_q[64:28]));
    end
  end

  // Division of both coordinates by the polynomial.
  logic signed [31:0] quot [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    pxud_div u_div (
      .clk_i     (clk_i),
      .en_i      (en),
      .mag_i     (s9_mag_q[l]),
      .neg_i     (s9_neg_q[l]),
      .divisor_i (s9_d_q[pxud_pkg::DIVR_W-1:0]),
      .quot_o    (quot[l])
    );
  end

  logic inv_q [pxud_pkg::DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q[0] <= s9_d_q[38] || (s9_d_q == '0);
      for (int k = 1; k < pxud_pkg::DIV_LAT; k++) begin
        inv_q[k] <= inv_q[k-1];
      end
    end
  end

  // Depth scaling, then offset and saturation feed the output register.
  logic signed [63:0] p1_prod_q [2];
  logic               p1_inv_q;
  logic signed [63:0] w_diff [2];
  logic signed [31:0] w_res [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        p1_prod_q[l] <= quot[l] * $signed({1'b0, depth_q});
      end
      p1_inv_q <= inv_q[pxud_pkg::DIV_LAT-1];
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      w_diff[l] = 64'(off_q[l]) - (p1_prod_q[l] >>> pxud_pkg::FRAC);
      w_res[l]  = p1_inv_q ? '0 : sat_s32(w_diff[l]);
    end
  end

  // Output register with one skid entry.
  logic signed [31:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic               out_inv_q, skid_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (v_q[LAST]) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_x_q   <= skid_x_q;
        out_y_q   <= skid_y_q;
        out_inv_q <= skid_inv_q;
      end
    end else if (v_q[LAST]) begin
      if (!out_valid_q || out_ready_i) begin
        out_x_q   <= w_res[0];
        out_y_q   <= w_res[1];
        out_inv_q <= p1_inv_q;
      end else begin
        skid_x_q   <= w_res[0];
        skid_y_q   <= w_res[1];
        skid_inv_q <= p1_inv_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign world_x_o   = out_x_q;
  assign world_y_o   = out_y_q;
  assign invalid_o   = out_inv_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(v_q))
    else $error("pipeline advanced while frozen");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |-> (world_x_o == '0 && world_y_o == '0))
    else $error("invalid result carries nonzero coordinates");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid loaded without an output stall");

endmodule
